>>> rtl/core/shell_line_tokenizer_defines.svh
// Assertion macros used by the tokenizer checker.
`ifndef SHELL_LINE_TOKENIZER_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/slt_pkg.sv
// Shared types and character constants of the shell line tokenizer.
package slt_pkg;

    typedef logic [7:0] byte_t;

    // Characters the lexer reacts to
    localparam byte_t CH_PIPE    = 8'h7C;
    localparam byte_t CH_AMP     = 8'h26;
    localparam byte_t CH_SEMI    = 8'h3B;
    localparam byte_t CH_GT      = 8'h3E;
    localparam byte_t CH_LT      = 8'h3C;
    localparam byte_t CH_LPAR    = 8'h28;
    localparam byte_t CH_RPAR    = 8'h29;
    localparam byte_t CH_HASH    = 8'h23;
    localparam byte_t CH_DQUOTE  = 8'h22;
    localparam byte_t CH_SQUOTE  = 8'h27;
    localparam byte_t CH_BSLASH  = 8'h5C;
    localparam byte_t CH_B       = 8'h62;
    localparam byte_t CH_R       = 8'h72;
    localparam byte_t CH_N       = 8'h6E;
    localparam byte_t CH_T       = 8'h74;
    localparam byte_t CH_F       = 8'h66;
    localparam byte_t CH_V       = 8'h76;
    localparam byte_t CH_SPACE   = 8'h20;
    localparam byte_t CH_TAB     = 8'h09;
    localparam byte_t CH_LF      = 8'h0A;
    localparam byte_t CH_VT      = 8'h0B;
    localparam byte_t CH_BS      = 8'h08;
    localparam byte_t CH_CR      = 8'h0D;
    localparam byte_t CH_FF      = 8'h0C;

    // Output segments of one item, in emission order
    typedef logic [2:0] seg_t;
    localparam seg_t SEG_IDLE = 3'd0;
    localparam seg_t SEG_PRE  = 3'd1;  // previously held operator (one or doubled)
    localparam seg_t SEG_WORD = 3'd2;  // pending word from the buffer
    localparam seg_t SEG_POST = 3'd3;  // escaped bytes or overflow notice
    localparam seg_t SEG_FOP  = 3'd4;  // operator flushed at end of line
    localparam seg_t SEG_MARK = 3'd5;  // bare end-of-line marker

    // What one item will emit
    typedef struct packed {
        logic [1:0] pre_n;
        logic       has_word;
        logic [1:0] post_n;
        logic       fop;
        logic       mark;
        logic       last;
    } plan_flags_t;

    typedef struct packed {
        logic load;
        logic emit;
        seg_t seg;
        logic sub;
        logic last_beat;
    } cmd_t;

    typedef struct packed {
        plan_flags_t plan_new;
        plan_flags_t plan;
        logic        word_last;
        logic        out_free;
    } status_t;

endpackage

>>> rtl/core/slt_ctrl.sv
// Sequencer that walks the output segments of each accepted item.
module slt_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  slt_pkg::status_t status,
    output slt_pkg::cmd_t    cmd
);

    slt_pkg::seg_t seg_reg;
    slt_pkg::seg_t seg_next;
    logic          sub_reg;
    logic          sub_next;
    logic          active;
    logic          seg_done;

    // First non-empty segment after the given one
    function automatic slt_pkg::seg_t next_seg(input slt_pkg::seg_t from,
                                               input slt_pkg::plan_flags_t f);
        slt_pkg::seg_t result;
        result = slt_pkg::SEG_IDLE;
        if (from < slt_pkg::SEG_MARK && f.mark)
            result = slt_pkg::SEG_MARK;
        if (from < slt_pkg::SEG_FOP && f.fop)
            result = slt_pkg::SEG_FOP;
        if (from < slt_pkg::SEG_POST && f.post_n != 2'd0)
            result = slt_pkg::SEG_POST;
        if (from < slt_pkg::SEG_WORD && f.has_word)
            result = slt_pkg::SEG_WORD;
        if (from < slt_pkg::SEG_PRE && f.pre_n != 2'd0)
            result = slt_pkg::SEG_PRE;
        return result;
    endfunction

    assign in_stall = (seg_reg != slt_pkg::SEG_IDLE);

    // Segment sequencing
    always_comb
    begin
        seg_next      = seg_reg;
        sub_next      = sub_reg;
        active        = 1'b0;
        seg_done      = 1'b0;
        cmd           = '0;
        cmd.seg       = seg_reg;
        cmd.sub       = sub_reg;
        case (seg_reg)
            slt_pkg::SEG_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    seg_next = next_seg(slt_pkg::SEG_IDLE, status.plan_new);
                    sub_next = 1'b0;
                end
            end
            slt_pkg::SEG_PRE:
            begin
                active   = 1'b1;
                seg_done = (sub_reg == status.plan.pre_n[1]);
            end
            slt_pkg::SEG_WORD:
            begin
                active   = 1'b1;
                seg_done = status.word_last;
            end
            slt_pkg::SEG_POST:
            begin
                active   = 1'b1;
                seg_done = (sub_reg == status.plan.post_n[1]);
            end
            slt_pkg::SEG_FOP, slt_pkg::SEG_MARK:
            begin
                active   = 1'b1;
                seg_done = 1'b1;
            end
            default:
            begin
                seg_next = slt_pkg::SEG_IDLE;
            end
        endcase

        // One beat per free output slot
        if (active && status.out_free)
        begin
            cmd.emit = 1'b1;
            if (seg_done)
            begin
                seg_next      = next_seg(seg_reg, status.plan);
                sub_next      = 1'b0;
                cmd.last_beat = (seg_next == slt_pkg::SEG_IDLE);
            end
            else
            begin
                sub_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= slt_pkg::SEG_IDLE;
            sub_reg <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            sub_reg <= sub_next;
        end
    end

endmodule

>>> rtl/core/slt_datapath.sv
// Lexer state, word buffer, per-item emission plan and output register.
module slt_datapath
#(
    parameter int WORD_MAX = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             line_last,
    input  slt_pkg::cmd_t    cmd,
    output slt_pkg::status_t status,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       tok_byte,
    output logic             has_byte,
    output logic             token_end,
    output logic             line_done,
    output logic             overflow
);

    localparam int LEN_W = $clog2(WORD_MAX + 1);
    localparam int IDX_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_ONE   = 2'd1;
    localparam logic [1:0] ESC_MULTI = 2'd2;

    // Lexer state
    logic [LEN_W-1:0] wl_reg, wl_next;
    logic             dq_reg, dq_next;
    logic             sq_reg, sq_next;
    logic [7:0]       hop_reg, hop_next;
    logic             oph_reg, oph_next;
    logic [1:0]       esc_reg, esc_next;
    logic             skip_reg, skip_next;

    // Outcome of the current byte
    logic [LEN_W-1:0] proc_wl;
    logic             proc_dq, proc_sq, proc_oph, proc_skip;
    logic [7:0]       proc_hop;
    logic [1:0]       proc_esc;
    logic [1:0]       pre_n, post_n;
    logic             pflush, store, store_ok, post_ovf, post_two;
    logic             finished, esc_go;
    logic [LEN_W-1:0] emit_len;
    slt_pkg::plan_flags_t plan_new;

    // Plan of the item being emitted
    slt_pkg::plan_flags_t plan_reg;
    logic [7:0]       hop_plan_reg;
    logic [LEN_W-1:0] len_plan_reg;
    logic             ovf_plan_reg;
    logic             two_plan_reg;
    logic [7:0]       c_plan_reg;
    logic [7:0]       fopb_plan_reg;

    // Word buffer
    logic [7:0]       mem [WORD_MAX];
    logic [7:0]       rd_reg;
    logic [LEN_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_en;
    logic             word_last;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       tok_byte_reg, tok_byte_next;
    logic             has_byte_reg, has_byte_next;
    logic             token_end_reg, token_end_next;
    logic             line_done_reg, line_done_next;
    logic             overflow_reg, overflow_next;
    logic             out_free;

    function automatic logic is_space(input logic [7:0] c);
        return c == slt_pkg::CH_SPACE || c == slt_pkg::CH_TAB || c == slt_pkg::CH_LF ||
               c == slt_pkg::CH_VT || c == slt_pkg::CH_BS || c == slt_pkg::CH_CR ||
               c == slt_pkg::CH_FF;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == slt_pkg::CH_PIPE || c == slt_pkg::CH_AMP || c == slt_pkg::CH_SEMI ||
               c == slt_pkg::CH_GT || c == slt_pkg::CH_LT || c == slt_pkg::CH_LPAR ||
               c == slt_pkg::CH_RPAR;
    endfunction

    function automatic logic is_esc_letter(input logic [7:0] c);
        return c == slt_pkg::CH_B || c == slt_pkg::CH_R || c == slt_pkg::CH_N ||
               c == slt_pkg::CH_T || c == slt_pkg::CH_F || c == slt_pkg::CH_V;
    endfunction

    // Classify the incoming byte against the lexer state
    always_comb
    begin
        proc_wl   = wl_reg;
        proc_dq   = dq_reg;
        proc_sq   = sq_reg;
        proc_hop  = hop_reg;
        proc_oph  = oph_reg;
        proc_esc  = esc_reg;
        proc_skip = skip_reg;
        pre_n     = 2'd0;
        post_n    = 2'd0;
        pflush    = 1'b0;
        store     = 1'b0;
        post_ovf  = 1'b0;
        post_two  = 1'b0;
        finished  = 1'b0;
        esc_go    = 1'b1;
        if (!skip_reg)
        begin
            // held operator: doubles up or goes out alone
            if (oph_reg)
            begin
                proc_oph = 1'b0;
                proc_hop = 8'h00;
                if (in_byte == hop_reg)
                begin
                    pre_n    = 2'd2;
                    finished = 1'b1;
                end
                else
                begin
                    pre_n = 2'd1;
                end
            end
            if (!finished)
            begin
                if (dq_reg)
                begin
                    if (in_byte == slt_pkg::CH_DQUOTE)
                    begin
                        pflush  = 1'b1;
                        proc_dq = 1'b0;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
                else if (sq_reg)
                begin
                    if (in_byte == slt_pkg::CH_SQUOTE)
                    begin
                        pflush  = 1'b1;
                        proc_sq = 1'b0;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
                else
                begin
                    // pending backslashes
                    if (esc_reg != ESC_NONE)
                    begin
                        if (in_byte == slt_pkg::CH_BSLASH)
                        begin
                            proc_esc = ESC_MULTI;
                            esc_go   = 1'b0;
                        end
                        else if (in_byte == slt_pkg::CH_DQUOTE ||
                                 in_byte == slt_pkg::CH_SQUOTE)
                        begin
                            pflush   = 1'b1;
                            post_n   = 2'd1;
                            proc_esc = ESC_NONE;
                            esc_go   = 1'b0;
                        end
                        else if (esc_reg == ESC_MULTI && is_esc_letter(in_byte))
                        begin
                            pflush   = 1'b1;
                            post_n   = 2'd2;
                            post_two = 1'b1;
                            proc_esc = ESC_NONE;
                            esc_go   = 1'b0;
                        end
                        else
                        begin
                            proc_esc = ESC_NONE;
                        end
                    end
                    if (esc_go)
                    begin
                        if (in_byte == slt_pkg::CH_BSLASH)
                        begin
                            proc_esc = ESC_ONE;
                        end
                        else if (in_byte == slt_pkg::CH_DQUOTE)
                        begin
                            pflush  = 1'b1;
                            proc_dq = 1'b1;
                        end
                        else if (in_byte == slt_pkg::CH_SQUOTE)
                        begin
                            pflush  = 1'b1;
                            proc_sq = 1'b1;
                        end
                        else if (is_space(in_byte))
                        begin
                            pflush = 1'b1;
                        end
                        else if (in_byte == slt_pkg::CH_HASH)
                        begin
                            pflush    = 1'b1;
                            proc_skip = 1'b1;
                        end
                        else if (is_op(in_byte))
                        begin
                            pflush   = 1'b1;
                            proc_hop = in_byte;
                            proc_oph = 1'b1;
                        end
                        else
                        begin
                            store = 1'b1;
                        end
                    end
                end
            end
        end

        // word length update and overflow
        store_ok = store && (wl_reg < LEN_W'(WORD_MAX));
        if (pflush)
            proc_wl = '0;
        if (store_ok)
            proc_wl = wl_reg + LEN_W'(1);
        if (store && !store_ok)
        begin
            proc_wl   = '0;
            proc_dq   = 1'b0;
            proc_sq   = 1'b0;
            proc_esc  = ESC_NONE;
            proc_skip = 1'b1;
            post_n    = 2'd1;
            post_ovf  = 1'b1;
        end

        emit_len          = pflush ? wl_reg : (line_last ? proc_wl : '0);
        plan_new.pre_n    = pre_n;
        plan_new.has_word = (emit_len != '0);
        plan_new.post_n   = post_n;
        plan_new.fop      = line_last && proc_oph;
        plan_new.mark     = line_last && !(pre_n != 2'd0 || emit_len != '0 ||
                                            post_n != 2'd0 || proc_oph);
        plan_new.last     = line_last;
    end

    // Lexer state next values; end of line returns to reset values
    always_comb
    begin
        wl_next   = wl_reg;
        dq_next   = dq_reg;
        sq_next   = sq_reg;
        hop_next  = hop_reg;
        oph_next  = oph_reg;
        esc_next  = esc_reg;
        skip_next = skip_reg;
        if (cmd.load)
        begin
            if (line_last)
            begin
                wl_next   = '0;
                dq_next   = 1'b0;
                sq_next   = 1'b0;
                hop_next  = 8'h00;
                oph_next  = 1'b0;
                esc_next  = ESC_NONE;
                skip_next = 1'b0;
            end
            else
            begin
                wl_next   = proc_wl;
                dq_next   = proc_dq;
                sq_next   = proc_sq;
                hop_next  = proc_hop;
                oph_next  = proc_oph;
                esc_next  = proc_esc;
                skip_next = proc_skip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= '0;
            dq_reg   <= 1'b0;
            sq_reg   <= 1'b0;
            hop_reg  <= 8'h00;
            oph_reg  <= 1'b0;
            esc_reg  <= ESC_NONE;
            skip_reg <= 1'b0;
            plan_reg <= '0;
        end
        else
        begin
            wl_reg   <= wl_next;
            dq_reg   <= dq_next;
            sq_reg   <= sq_next;
            hop_reg  <= hop_next;
            oph_reg  <= oph_next;
            esc_reg  <= esc_next;
            skip_reg <= skip_next;
            if (cmd.load)
                plan_reg <= plan_new;
        end
    end

    // Plan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hop_plan_reg  <= hop_reg;
            len_plan_reg  <= emit_len;
            ovf_plan_reg  <= post_ovf;
            two_plan_reg  <= post_two;
            c_plan_reg    <= in_byte;
            fopb_plan_reg <= proc_hop;
        end
    end

    // Word buffer: write on accept, registered read that tracks the pointer
    assign wr_en    = cmd.load && store_ok;
    assign wr_idx   = wl_reg[IDX_W-1:0];
    assign ptr_next = cmd.load ? '0 :
                      ((cmd.emit && cmd.seg == slt_pkg::SEG_WORD) ?
                       ptr_reg + LEN_W'(1) : ptr_reg);
    assign rd_idx   = (ptr_next < LEN_W'(WORD_MAX)) ? ptr_next[IDX_W-1:0] : '0;
    assign word_last = (ptr_reg + LEN_W'(1) == len_plan_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= in_byte;
        if (wr_en && wr_idx == rd_idx)
            rd_reg <= in_byte;
        else
            rd_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else
            ptr_reg <= ptr_next;
    end

    // Output beat selection
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        tok_byte_next  = tok_byte_reg;
        has_byte_next  = has_byte_reg;
        token_end_next = token_end_reg;
        line_done_next = line_done_reg;
        overflow_next  = overflow_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            tok_byte_next  = 8'h00;
            has_byte_next  = 1'b1;
            token_end_next = 1'b1;
            line_done_next = cmd.last_beat && plan_reg.last;
            overflow_next  = 1'b0;
            case (cmd.seg)
                slt_pkg::SEG_PRE:
                begin
                    tok_byte_next  = hop_plan_reg;
                    token_end_next = (cmd.sub == plan_reg.pre_n[1]);
                end
                slt_pkg::SEG_WORD:
                begin
                    tok_byte_next  = rd_reg;
                    token_end_next = word_last;
                end
                slt_pkg::SEG_POST:
                begin
                    if (ovf_plan_reg)
                    begin
                        has_byte_next  = 1'b0;
                        token_end_next = 1'b0;
                        overflow_next  = 1'b1;
                    end
                    else if (two_plan_reg && !cmd.sub)
                    begin
                        tok_byte_next  = slt_pkg::CH_BSLASH;
                        token_end_next = 1'b0;
                    end
                    else
                    begin
                        tok_byte_next = c_plan_reg;
                    end
                end
                slt_pkg::SEG_FOP:
                begin
                    tok_byte_next = fopb_plan_reg;
                end
                default:
                begin
                    has_byte_next  = 1'b0;
                    token_end_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        tok_byte_reg  <= tok_byte_next;
        has_byte_reg  <= has_byte_next;
        token_end_reg <= token_end_next;
        line_done_reg <= line_done_next;
        overflow_reg  <= overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign tok_byte  = tok_byte_reg;
    assign has_byte  = has_byte_reg;
    assign token_end = token_end_reg;
    assign line_done = line_done_reg;
    assign overflow  = overflow_reg;

    assign status.plan_new  = plan_new;
    assign status.plan      = plan_reg;
    assign status.word_last = word_last;
    assign status.out_free  = out_free;

endmodule

>>> rtl/core/shell_line_tokenizer.sv
// Shell command-line tokenizer: one input byte in, token bytes out one beat at a time.
// Each input beat is accepted in the idle state, then its result beats are emitted one per cycle
// while the output side is not stalling; a byte that causes no result leaves the sequencer idle,
// and the next byte is taken once the last result beat of the current one has been
// loaded into the output register. The WORD_MAX-byte word buffer has a single read port,
// which returns one buffered word byte per cycle when a word is flushed and the output
// side is not stalling. The word buffer needs no clearing after reset. Results carry
// tok_byte, has_byte, token_end, line_done and overflow; line_done marks the final beat
// caused by a byte with line_last set.
module shell_line_tokenizer
#(
    parameter int WORD_MAX = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       line_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tok_byte,
    output logic       has_byte,
    output logic       token_end,
    output logic       line_done,
    output logic       overflow
);

    slt_pkg::cmd_t    cmd;
    slt_pkg::status_t status;

    // Segment sequencer
    slt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Lexer state, word buffer and output register
    slt_datapath
    #(
        .WORD_MAX (WORD_MAX)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .line_last (line_last),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tok_byte  (tok_byte),
        .has_byte  (has_byte),
        .token_end (token_end),
        .line_done (line_done),
        .overflow  (overflow)
    );

endmodule

>>> rtl/core/slt_checker.sv
// Port-level checker for the shell line tokenizer, bound to the top level.
`include "shell_line_tokenizer_defines.svh"

module slt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] tok_byte,
    input logic       has_byte,
    input logic       token_end,
    input logic       line_done,
    input logic       overflow
);

    // A stalled result beat holds
    `SLT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tok_byte) && $stable(has_byte) && $stable(line_done), "stalled result beat changed")

    // A beat with no byte carries a zero byte
    `SLT_ASSERT_NOW(a_empty_zero, out_valid && !has_byte, tok_byte == 8'h00, "empty beat with nonzero byte")

    // The overflow notice carries no byte and ends no token
    `SLT_ASSERT_NOW(a_ovf_shape, out_valid && overflow, !has_byte && !token_end, "malformed overflow notice")

    // A byteless beat that is not an overflow notice is the end-of-line marker
    `SLT_ASSERT_NOW(a_bare_marker, out_valid && !has_byte && !overflow, line_done, "bare marker without line_done")

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (.*);
